[design/lta_pkg.sv]
// ----------------------------------------------------------------------------
// lta_pkg: shared types and constants for the lottery ticket arbiter
// Sequencer states, item command codes, field widths and the LCG constants.
// ----------------------------------------------------------------------------
package lta_pkg;

  // Item commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_DRAW  = 1'b1;

  // Fixed port field widths
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned REPORT_W = 22;

  // Linear congruential generator
  localparam int unsigned SEED_W   = 64;
  localparam int unsigned HALF_W   = 32;
  localparam int unsigned LCG_MUL_W = 21;
  localparam logic [LCG_MUL_W-1:0] LCG_MUL    = 21'd1664525;
  localparam logic [SEED_W-1:0]    LCG_INC    = 64'd1013904223;
  localparam logic [SEED_W-1:0]    SEED_RESET = 64'd12345;

  // Divider steps, one quotient bit per step
  localparam int unsigned STEP_W = 6;
  localparam logic [STEP_W-1:0] LAST_STEP = 6'd63;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_SEED,
    ST_DIV,
    ST_WALK,
    ST_DONE
  } lta_state_t;

endpackage

[design/lta_ram.sv]
// ----------------------------------------------------------------------------
// lta_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lta_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/lta_lcg.sv]
// ----------------------------------------------------------------------------
// lta_lcg: 64-bit linear congruential seed
// seed = seed * MUL + INC mod 2^64, done on one shared 32x21 multiplier:
// low half product plus increment first, then the high half product shifted.
// ----------------------------------------------------------------------------
module lta_lcg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      done,
  output logic [lta_pkg::SEED_W-1:0] seed
);
  import lta_pkg::*;

  logic                          busy;
  logic [SEED_W-1:0]             acc;
  logic [HALF_W-1:0]             operand;
  logic [HALF_W+LCG_MUL_W-1:0]   prod;

  // Shared multiplier: low half on the first step, high half on the second
  assign operand = busy ? seed[SEED_W-1:HALF_W] : seed[HALF_W-1:0];
  assign prod    = operand * LCG_MUL;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      seed <= SEED_RESET;
    end else begin
      done <= 1'b0;
      if (busy) begin
        seed <= acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
        busy <= 1'b0;
        done <= 1'b1;
      end else if (start) begin
        busy <= 1'b1;
      end
    end
  end

  // Partial sum of the low half
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      acc <= SEED_W'(prod) + LCG_INC;
    end
  end

endmodule

[design/lta_mod.sv]
// ----------------------------------------------------------------------------
// lta_mod: iterative 64-bit modulo
// Restoring division, one dividend bit per cycle, keeping the remainder only.
// ----------------------------------------------------------------------------
module lta_mod #(
  parameter int unsigned DIVISOR_W = 22
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lta_pkg::SEED_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]       divisor,
  output logic                       done,
  output logic [DIVISOR_W-1:0]       remainder
);
  import lta_pkg::*;

  logic                 busy;
  logic [STEP_W-1:0]    step;
  logic [SEED_W-1:0]    shift;
  logic [DIVISOR_W-1:0] dvsr;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;

  // One compare and subtract per step
  assign trial = {remainder, shift[SEED_W-1]};
  assign diff  = trial - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (start) begin
        busy <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (!busy && start) begin
      shift     <= dividend;
      dvsr      <= divisor;
      remainder <= '0;
      step      <= '0;
    end else if (busy) begin
      shift <= {shift[SEED_W-2:0], 1'b0};
      step  <= step + STEP_W'(1);
      if (trial >= {1'b0, dvsr}) begin
        remainder <= diff[DIVISOR_W-1:0];
      end else begin
        remainder <= trial[DIVISOR_W-1:0];
      end
    end
  end

endmodule

[design/lottery_ticket_arbiter.sv]
// ----------------------------------------------------------------------------
// lottery_ticket_arbiter: proportional-share lottery arbiter
// Sequencer, slot stores and result register around the seed and modulo units.
// ----------------------------------------------------------------------------
// A write item stores one slot's tickets and runnable flag. A draw item runs
// from its transfer to the result through the accept cycle, one pass over
// the ticket RAM to sum the runnable tickets, a step of the 64-bit seed on a
// shared 32-bit multiplier, the 64-step restoring division that gives the
// winning ticket, a second RAM pass that walks the prefix sum until the
// winner is found, and the load of the output register. A draw with no
// runnable tickets ends after the first pass. The RAM read port sets the pace
// of both passes; the block takes no new item until the current result is in
// the output register. Runnable flags reset to zero, so the ticket RAM needs
// no clearing.
// ----------------------------------------------------------------------------
module lottery_ticket_arbiter #(
  parameter int unsigned SLOT_COUNT  = 64,
  parameter int unsigned TICKET_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         command,
  input  logic [lta_pkg::INDEX_W-1:0]  slot_index,
  input  logic [lta_pkg::COUNT_W-1:0]  ticket_count,
  input  logic                         ready_flag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         granted,
  output logic [lta_pkg::INDEX_W-1:0]  winner_slot,
  output logic [lta_pkg::REPORT_W-1:0] ticket_total,
  output logic [lta_pkg::REPORT_W-1:0] drawn_ticket
);
  import lta_pkg::*;

  localparam int unsigned AW    = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int unsigned SUM_W = TICKET_BITS + AW;

  lta_state_t state, state_next;

  logic [SLOT_COUNT-1:0]  runnable;
  logic [CNT_W-1:0]       cnt;
  logic                   pipe_v;
  logic [AW-1:0]          pipe_idx;
  logic [TICKET_BITS-1:0] rd_data;
  logic [SUM_W-1:0]       total;
  logic [SUM_W-1:0]       prefix;
  logic [SUM_W-1:0]       reach;
  logic [SUM_W-1:0]       win;

  logic                   res_granted;
  logic [AW-1:0]          res_slot;
  logic [SUM_W-1:0]       res_total;
  logic [SUM_W-1:0]       res_win;

  logic in_xfer;
  logic wr_ok;
  logic issue;
  logic pass_end;
  logic hit;
  logic lcg_start;
  logic lcg_done;
  logic mod_done;
  logic [SEED_W-1:0] seed;

  assign in_xfer  = in_valid && in_ready;
  assign wr_ok    = in_xfer && (command == CMD_WRITE) && (32'(slot_index) < SLOT_COUNT);
  assign issue    = ((state == ST_SUM) || (state == ST_WALK)) && (cnt != CNT_W'(SLOT_COUNT));
  assign pass_end = (cnt == CNT_W'(SLOT_COUNT)) && !pipe_v;
  assign reach    = prefix + SUM_W'(rd_data);
  assign hit      = pipe_v && runnable[pipe_idx] && (reach > win);
  assign lcg_start = (state == ST_SUM) && pass_end && (total != '0);

  // Ticket store
  lta_ram #(
    .WIDTH (TICKET_BITS),
    .DEPTH (SLOT_COUNT)
  ) u_tickets (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (AW'(slot_index)),
    .wdata (TICKET_BITS'(ticket_count)),
    .raddr (cnt[AW-1:0]),
    .rdata (rd_data)
  );

  // Seed generator
  lta_lcg u_lcg (
    .clk   (clk),
    .rst   (rst),
    .start (lcg_start),
    .done  (lcg_done),
    .seed  (seed)
  );

  // Winning ticket: seed mod total
  lta_mod #(
    .DIVISOR_W (SUM_W)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (lcg_done),
    .dividend  (seed),
    .divisor   (total),
    .done      (mod_done),
    .remainder (win)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (command == CMD_DRAW) ? ST_SUM : ST_DONE;
        end
      end
      ST_SUM: begin
        if (pass_end) begin
          state_next = (total != '0) ? ST_SEED : ST_DONE;
        end
      end
      ST_SEED: begin
        if (lcg_done) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (mod_done) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (hit || pass_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Slot pass counter and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_v <= 1'b0;
    end else begin
      pipe_v <= issue;
    end
  end

  always_ff @(posedge clk) begin
    pipe_idx <= cnt[AW-1:0];
    if ((state == ST_IDLE) || (state == ST_DIV)) begin
      cnt <= '0;
    end else if (issue) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  // Total and prefix sums
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      total <= '0;
    end else if ((state == ST_SUM) && pipe_v && runnable[pipe_idx]) begin
      total <= total + SUM_W'(rd_data);
    end
    if (state == ST_DIV) begin
      prefix <= '0;
    end else if ((state == ST_WALK) && pipe_v && runnable[pipe_idx]) begin
      prefix <= reach;
    end
  end

  // Runnable flags: set by writes, cleared on grant
  always_ff @(posedge clk) begin
    if (rst) begin
      runnable <= '0;
    end else if (wr_ok) begin
      runnable[AW'(slot_index)] <= ready_flag;
    end else if ((state == ST_WALK) && hit) begin
      runnable[pipe_idx] <= 1'b0;
    end
  end

  // Pending result
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      res_granted <= 1'b0;
      res_slot    <= '0;
      res_total   <= '0;
      res_win     <= '0;
    end else if (state == ST_WALK) begin
      if (hit) begin
        res_granted <= 1'b1;
        res_slot    <= pipe_idx;
        res_total   <= total;
        res_win     <= win;
      end else if (pass_end) begin
        res_total <= total;
        res_win   <= win;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!out_valid || out_ready)) begin
      granted      <= res_granted;
      winner_slot  <= INDEX_W'(res_slot);
      ticket_total <= REPORT_W'(res_total);
      drawn_ticket <= REPORT_W'(res_win);
    end
  end

endmodule

[dv/lottery_ticket_arbiter_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lottery_ticket_arbiter_tb: self-checking bench for the lottery arbiter
// A short directed table covers reset state, extremes, zero-ticket and
// non-runnable slots. Random write rounds followed by draws, with rare
// full-pool fills, then run against a cycle-free model of the ticket pool and seed.
// Both handshakes idle at random; every result is checked field by field.
// ----------------------------------------------------------------------------
module lottery_ticket_arbiter_tb;
  import lta_pkg::*;

  localparam int unsigned SLOTS        = 64;
  localparam int unsigned RAND_ITEMS   = 1200;
  localparam int unsigned DRAIN_CYCLES = 250;

  typedef struct packed {
    logic                g;
    logic [INDEX_W-1:0]  w;
    logic [REPORT_W-1:0] t;
    logic [REPORT_W-1:0] d;
  } grant_t;

  typedef struct packed {
    logic               cmd;
    logic [INDEX_W-1:0] slot;
    logic [COUNT_W-1:0] count;
    logic               flag;
    logic               typed;  // use the typed-in result instead of the model
    grant_t             want;
  } stim_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_COMB, RX_CHOKE} rx_mode_t;

  localparam grant_t NO_GRANT = '0;
  localparam int unsigned DIR_ROWS = 21;

  // Directed stimulus; draw rows carry junk in the ignored fields
  stim_row_t dir_table [0:DIR_ROWS-1] = '{
    '{CMD_DRAW,  6'h3F, 16'hFFFF, 1'b1, 1'b1, NO_GRANT},  // nothing runnable yet
    '{CMD_WRITE, 6'd0,  16'hFFFF, 1'b1, 1'b1, NO_GRANT},
    '{CMD_WRITE, 6'd63, 16'hFFFF, 1'b1, 1'b1, NO_GRANT},
    '{CMD_DRAW,  6'h00, 16'h0000, 1'b0, 1'b0, NO_GRANT},
    '{CMD_DRAW,  6'h2A, 16'h5A5A, 1'b1, 1'b0, NO_GRANT},
    '{CMD_DRAW,  6'h15, 16'hA5A5, 1'b0, 1'b1, NO_GRANT},  // both winners retired
    '{CMD_WRITE, 6'd5,  16'h0000, 1'b1, 1'b1, NO_GRANT},  // runnable, no tickets
    '{CMD_DRAW,  6'h00, 16'h0000, 1'b0, 1'b1, NO_GRANT},  // zero pool, seed held
    '{CMD_WRITE, 6'd6,  16'h0001, 1'b1, 1'b1, NO_GRANT},
    '{CMD_DRAW,  6'h3F, 16'hFFFF, 1'b1, 1'b1, '{1'b1, 6'd6, 22'd1, 22'd0}},
    '{CMD_WRITE, 6'd7,  16'd100,  1'b0, 1'b1, NO_GRANT},  // parked, not runnable
    '{CMD_DRAW,  6'h00, 16'h0000, 1'b0, 1'b1, NO_GRANT},
    '{CMD_WRITE, 6'd42, 16'h5555, 1'b1, 1'b1, NO_GRANT},
    '{CMD_WRITE, 6'd21, 16'hAAAA, 1'b1, 1'b1, NO_GRANT},
    '{CMD_WRITE, 6'd32, 16'h8000, 1'b1, 1'b1, NO_GRANT},
    '{CMD_WRITE, 6'd31, 16'h7FFF, 1'b1, 1'b1, NO_GRANT},
    '{CMD_WRITE, 6'd21, 16'h1234, 1'b0, 1'b1, NO_GRANT},  // rewrite drops runnable
    '{CMD_DRAW,  6'h11, 16'h0F0F, 1'b0, 1'b0, NO_GRANT},
    '{CMD_DRAW,  6'h22, 16'hF0F0, 1'b1, 1'b0, NO_GRANT},
    '{CMD_DRAW,  6'h33, 16'h3C3C, 1'b0, 1'b0, NO_GRANT},
    '{CMD_DRAW,  6'h0C, 16'hC3C3, 1'b1, 1'b1, NO_GRANT}   // pool drained again
  };

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic                command      = CMD_WRITE;
  logic [INDEX_W-1:0]  slot_index   = '0;
  logic [COUNT_W-1:0]  ticket_count = '0;
  logic                ready_flag   = 1'b0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic                granted;
  logic [INDEX_W-1:0]  winner_slot;
  logic [REPORT_W-1:0] ticket_total;
  logic [REPORT_W-1:0] drawn_ticket;

  // Model state of the ticket pool and the seed
  logic [COUNT_W-1:0] tk_count [SLOTS];
  logic               tk_live  [SLOTS];
  logic [SEED_W-1:0]  lcg_state;

  stim_row_t cur_row = '0;
  grant_t    pending_grants [$];
  int        mismatch_count = 0;
  int        items_sent     = 0;
  int        burst_left     = 0;

  rx_mode_t   rx_mode  = RX_OPEN;
  int         rx_hold  = 0;
  logic [2:0] rx_phase = '0;

  lottery_ticket_arbiter u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .slot_index   (slot_index),
    .ticket_count (ticket_count),
    .ready_flag   (ready_flag),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .granted      (granted),
    .winner_slot  (winner_slot),
    .ticket_total (ticket_total),
    .drawn_ticket (drawn_ticket)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Apply one item to the pool model and return the result it should give
  function automatic grant_t predict_draw(input logic cmd, input logic [INDEX_W-1:0] idx,
                                          input logic [COUNT_W-1:0] cnt, input logic flg);
    grant_t            res;
    logic [31:0]       pool;
    logic [31:0]       running;
    logic [SEED_W-1:0] pick;
    bit                found;
    res     = NO_GRANT;
    pool    = '0;
    running = '0;
    found   = 1'b0;
    if (cmd == CMD_WRITE) begin
      tk_count[idx] = cnt;
      tk_live[idx]  = flg;
      return res;
    end
    for (int s = 0; s < SLOTS; s++) begin
      if (tk_live[s]) pool += tk_count[s];
    end
    // Empty pool: no grant and the seed stays put
    if (pool == 0) return res;
    lcg_state = lcg_state * SEED_W'(LCG_MUL) + LCG_INC;
    pick      = lcg_state % SEED_W'(pool);
    // Prefix walk; first runnable slot whose range covers the pick wins
    for (int s = 0; s < SLOTS; s++) begin
      if (!found && tk_live[s]) begin
        if (SEED_W'(running) + SEED_W'(tk_count[s]) > pick) begin
          found      = 1'b1;
          tk_live[s] = 1'b0;
          res        = '{1'b1, INDEX_W'(s), pool[REPORT_W-1:0], pick[REPORT_W-1:0]};
        end
        running += tk_count[s];
      end
    end
    if (!found) res = '{1'b0, '0, pool[REPORT_W-1:0], pick[REPORT_W-1:0]};
    return res;
  endfunction

  // Ticket counts weighted toward the edges
  function automatic logic [COUNT_W-1:0] rand_count();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 5) return COUNT_W'($urandom_range(0, 3));
    if (sel < 7) return '1;
    if (sel < 9) return COUNT_W'(1);
    return COUNT_W'($urandom);
  endfunction

  function automatic stim_row_t write_row(input logic [INDEX_W-1:0] idx,
                                          input logic [COUNT_W-1:0] cnt, input logic flg);
    return '{CMD_WRITE, idx, cnt, flg, 1'b0, NO_GRANT};
  endfunction

  function automatic stim_row_t draw_row();
    return '{CMD_DRAW, INDEX_W'($urandom), COUNT_W'($urandom), 1'($urandom), 1'b0, NO_GRANT};
  endfunction

  // Present one item, hold it until the transfer, then maybe idle a while
  task automatic transfer_item(input stim_row_t row);
    command      <= row.cmd;
    slot_index   <= row.slot;
    ticket_count <= row.count;
    ready_flag   <= row.flag;
    cur_row      <= row;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Receiver back-pressure in one of four patterns, chosen anew at random
  always @(posedge clk) begin
    if (rx_hold == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_hold <= $urandom_range(50, 600);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    rx_phase <= rx_phase + 1'b1;
    case (rx_mode)
      RX_OPEN:  out_ready <= 1'b1;
      RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
      RX_COMB:  out_ready <= (rx_phase > 3'd2);
      default:  out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Predict on input transfers, check on output transfers
  always @(posedge clk) begin
    grant_t exp_res;
    grant_t model_res;
    if (!rst) begin
      if (in_valid && in_ready) begin
        model_res = predict_draw(command, slot_index, ticket_count, ready_flag);
        pending_grants.push_back(cur_row.typed ? cur_row.want : model_res);
      end
      if (out_valid && out_ready) begin
        if (pending_grants.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding");
        end else begin
          exp_res = pending_grants.pop_front();
          if (granted !== exp_res.g)
            report_mismatch($sformatf("granted got %b want %b", granted, exp_res.g));
          if (winner_slot !== exp_res.w)
            report_mismatch($sformatf("winner_slot got %0d want %0d", winner_slot, exp_res.w));
          if (ticket_total !== exp_res.t)
            report_mismatch($sformatf("ticket_total got %0d want %0d", ticket_total,
                                      exp_res.t));
          if (drawn_ticket !== exp_res.d)
            report_mismatch($sformatf("drawn_ticket got %0d want %0d", drawn_ticket,
                                      exp_res.d));
        end
      end
    end
  end

  initial begin
    int unsigned scenario;
    int unsigned n_writes;
    for (int s = 0; s < SLOTS; s++) begin
      tk_count[s] = '0;
      tk_live[s]  = 1'b0;
    end
    lcg_state = SEED_RESET;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) transfer_item(dir_table[r]);

    // Mostly write rounds then draws; rare full-pool fills; some noise
    while (items_sent < DIR_ROWS + RAND_ITEMS) begin
      scenario = $urandom_range(0, 299);
      if (scenario == 0) begin
        for (int s = 0; s < SLOTS; s++) transfer_item(write_row(INDEX_W'(s), '1, 1'b1));
        repeat (3) transfer_item(draw_row());
      end else if (scenario < 200) begin
        n_writes = $urandom_range(1, 8);
        repeat (n_writes) begin
          transfer_item(write_row(INDEX_W'($urandom), rand_count(),
                                  ($urandom_range(0, 9) != 0)));
        end
        repeat ($urandom_range(1, n_writes + 1)) transfer_item(draw_row());
      end else if (scenario < 250) begin
        transfer_item(draw_row());
      end else begin
        transfer_item(write_row(INDEX_W'($urandom), rand_count(), 1'($urandom)));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #12_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
design/lta_pkg.sv
design/lta_ram.sv
design/lta_lcg.sv
design/lta_mod.sv
design/lottery_ticket_arbiter.sv
dv/lottery_ticket_arbiter_tb.sv
